// ----- rtl/frde_pkg.sv -----
`timescale 1ns / 1ps

package frde_pkg;

	localparam int OP_W      = 2;
	localparam int TGT_W     = 2;
	localparam int A_W       = 12;
	localparam int B_W       = 20;
	localparam int C_W       = 20;
	localparam int RC_W      = 3;
	localparam int STAT_W    = 2;
	localparam int ADDR_W    = 8;
	localparam int CNT_W     = 4;
	localparam int BYTES_W   = 64;
	localparam int FBYTE_W   = 8;
	localparam int SCALE_SH  = 7;
	localparam int DIVD_W    = B_W + SCALE_SH;
	localparam int P1_W      = 18;
	localparam int IN_DATA_W = 64;
	localparam int OUT_DATA_W = 96;

	localparam logic [A_W-1:0] PLL_A_MIN = 12'd15;
	localparam logic [A_W-1:0] PLL_A_MAX = 12'd90;
	localparam logic [A_W-1:0] MS_A_MIN  = 12'd4;
	localparam logic [A_W-1:0] MS_A_MAX  = 12'd2048;
	localparam logic [P1_W-1:0] P1_OFFSET = 18'd512;

	localparam logic [ADDR_W-1:0] PLL_A_ADDR    = 8'd26;
	localparam logic [ADDR_W-1:0] PLL_B_ADDR    = 8'd34;
	localparam logic [ADDR_W-1:0] MS_BASE_ADDR  = 8'd42;
	localparam logic [ADDR_W-1:0] RDIV_BASE_ADDR = 8'd44;
	localparam logic [ADDR_W-1:0] PLL_RST_ADDR  = 8'd177;
	localparam logic [ADDR_W-1:0] CLK_CTRL_BASE = 8'd16;
	localparam logic [FBYTE_W-1:0] PLL_RST_BYTE  = 8'hA0;
	localparam logic [FBYTE_W-1:0] CLK_CTRL_BYTE = 8'h0F;
	localparam logic [FBYTE_W-1:0] CLK_CTRL_PLLB = 8'h20;
	localparam logic [FBYTE_W-1:0] CLK_CTRL_INT  = 8'h40;
	localparam logic [CNT_W-1:0] DIV_BYTE_CNT  = 4'd8;
	localparam logic [CNT_W-1:0] RDIV_BYTE_CNT = 4'd1;

	typedef enum logic [OP_W-1:0] {
		OP_PLL  = 2'd0,
		OP_MS   = 2'd1,
		OP_RDIV = 2'd2
	} frde_op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK          = 2'd0,
		STAT_NOT_ALLOWED = 2'd1,
		STAT_INVALID     = 2'd2
	} frde_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_DONE
	} frde_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} frde_div_stat_t;

	function automatic logic [BYTES_W-1:0] pack_divider(
		input logic [P1_W-1:0] p1,
		input logic [C_W-1:0]  p2,
		input logic [C_W-1:0]  p3,
		input logic [RC_W-1:0] rbits
	);
		pack_divider = {p3[15:8], p3[7:0], 1'b0, rbits, 2'b00, p1[17:16],
			p1[15:8], p1[7:0], p3[19:16], p2[19:16], p2[15:8], p2[7:0]};
	endfunction

endpackage

// ----- rtl/fractional_divider_register_encoder_core.sv -----
`timescale 1ns / 1ps
// Divider register encoder for a two-PLL clock synthesizer with NUM_OUTPUTS outputs.
// Input channel s_axis: tuser carries the operation (program PLL, program output
// divider, set R divider), tdata carries target, source PLL, a, b, c and R code.
// Output channel m_axis: tuser carries the status, tdata the start address, byte
// count, eight packed register bytes and the follow-up address and byte.
// A divider request runs b*128 / c through a one-bit-per-cycle restoring divider
// of 27 steps; its result then passes the DONE state into the output register.
// R divider requests and rejected requests skip the divider and go from CHECK to DONE.
// One request is in work at a time; s_axis_tready is high only while the
// sequencer is idle, so the block takes no new request until the current one
// has moved its result into the output register.
// The output register holds a finished result while m_axis_tready is low; the
// sequencer waits with the next result until that register is free, and accepts a
// new request as soon as its own result has moved into the output register.
// Reset clears the PLL-configured flags, the R divider codes and the stored P1 top
// bits of every output, and empties the output register.
module fractional_divider_register_encoder_core #(
	parameter int NUM_OUTPUTS = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// target[1:0], pll_source[2], integer_part[14:3], numerator[34:15],
	// denominator[54:35], rdiv_code[57:55], zero[63:58]
	input  logic [frde_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// operation[1:0]
	input  logic [frde_pkg::OP_W-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// start_address[7:0], byte_count[11:8], register_bytes[75:12],
	// follow_address[83:76], follow_byte[91:84], zero[95:92]
	output logic [frde_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// status[1:0]
	output logic [frde_pkg::STAT_W-1:0]      m_axis_tuser
);
	import frde_pkg::*;

	localparam int IDX_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
	localparam int TGT_X_W = (IDX_W > TGT_W) ? IDX_W : TGT_W;

	frde_state_t  state_q, state_d;
	frde_status_t status_q, status_c;
	logic         need_div;
	logic         accept, div_start, load_out;

	logic [OP_W-1:0]  op_q;
	logic [TGT_W-1:0] tgt_q;
	logic             src_q;
	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [C_W-1:0]   c_q;
	logic [RC_W-1:0]  rc_q;

	logic                pll_ready_q [2];
	logic [RC_W-1:0]     rdiv_q      [NUM_OUTPUTS];
	logic [1:0]          p1top_q     [NUM_OUTPUTS];
	logic [TGT_X_W-1:0]  tgt_x;
	logic [IDX_W-1:0]    ch_idx;
	logic                ch_ok;

	frde_div_stat_t      div_stat;
	logic [DIVD_W-1:0]   quo;
	logic [C_W-1:0]      rem;
	logic [P1_W-1:0]     p1;

	logic [ADDR_W-1:0]   addr_c, faddr_c;
	logic [CNT_W-1:0]    count_c;
	logic [BYTES_W-1:0]  bytes_c;
	logic [FBYTE_W-1:0]  fbyte_c;

	logic                    m_valid_q;
	logic [OUT_DATA_W-1:0]   m_data_q;
	logic [STAT_W-1:0]       m_stat_q;

	assign tgt_x  = TGT_X_W'(tgt_q);
	assign ch_idx = tgt_x[IDX_W-1:0];
	assign ch_ok  = int'(tgt_q) < NUM_OUTPUTS;

	always_comb begin
		status_c = STAT_INVALID;
		unique case (op_q)
			OP_PLL: begin
				if (a_q >= PLL_A_MIN && a_q <= PLL_A_MAX && c_q != '0 && tgt_q <= TGT_W'(1))
					status_c = STAT_OK;
			end
			OP_MS: begin
				if (a_q >= MS_A_MIN && a_q <= MS_A_MAX && c_q != '0) begin
					if (!pll_ready_q[src_q])
						status_c = STAT_NOT_ALLOWED;
					else if (ch_ok)
						status_c = STAT_OK;
				end
			end
			OP_RDIV: begin
				if (ch_ok)
					status_c = STAT_OK;
			end
			default: status_c = STAT_INVALID;
		endcase
		need_div = (status_c == STAT_OK) && (op_q == OP_PLL || op_q == OP_MS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				if (need_div) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (div_stat.done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_axis_tuser;
			tgt_q <= s_axis_tdata[1:0];
			src_q <= s_axis_tdata[2];
			a_q   <= s_axis_tdata[14:3];
			b_q   <= s_axis_tdata[34:15];
			c_q   <= s_axis_tdata[54:35];
			rc_q  <= s_axis_tdata[57:55];
		end
		if (state_q == S_CHECK)
			status_q <= status_c;
	end

	frde_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  ({b_q, {SCALE_SH{1'b0}}}),
		.divisor   (c_q),
		.stat      (div_stat),
		.quotient  (quo),
		.remainder (rem)
	);

	assign p1 = P1_W'({a_q, {SCALE_SH{1'b0}}}) + quo[P1_W-1:0] - P1_OFFSET;

	always_comb begin
		addr_c  = '0;
		count_c = '0;
		bytes_c = '0;
		faddr_c = '0;
		fbyte_c = '0;
		if (status_q == STAT_OK) begin
			unique case (op_q)
				OP_PLL: begin
					addr_c  = (tgt_q == '0) ? PLL_A_ADDR : PLL_B_ADDR;
					count_c = DIV_BYTE_CNT;
					bytes_c = pack_divider(p1, rem, c_q, '0);
					faddr_c = PLL_RST_ADDR;
					fbyte_c = PLL_RST_BYTE;
				end
				OP_MS: begin
					addr_c  = MS_BASE_ADDR + ADDR_W'({tgt_q, 3'b000});
					count_c = DIV_BYTE_CNT;
					bytes_c = pack_divider(p1, rem, c_q, rdiv_q[ch_idx]);
					faddr_c = CLK_CTRL_BASE + ADDR_W'(tgt_q);
					fbyte_c = CLK_CTRL_BYTE | (src_q ? CLK_CTRL_PLLB : '0) |
						((b_q == '0) ? CLK_CTRL_INT : '0);
				end
				OP_RDIV: begin
					addr_c  = RDIV_BASE_ADDR + ADDR_W'({tgt_q, 3'b000});
					count_c = RDIV_BYTE_CNT;
					bytes_c = {1'b0, rc_q, 2'b00, p1top_q[ch_idx], {(BYTES_W-8){1'b0}}};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pll_ready_q[0] <= 1'b0;
			pll_ready_q[1] <= 1'b0;
			for (int i = 0; i < NUM_OUTPUTS; i++) begin
				rdiv_q[i]  <= '0;
				p1top_q[i] <= '0;
			end
		end else if (load_out && status_q == STAT_OK) begin
			case (op_q)
				OP_PLL:  pll_ready_q[tgt_q[0]] <= 1'b1;
				OP_MS:   p1top_q[ch_idx] <= p1[P1_W-1:P1_W-2];
				OP_RDIV: rdiv_q[ch_idx] <= rc_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (load_out)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {4'b0000, fbyte_c, faddr_c, bytes_c, count_c, addr_c};
			m_stat_q <= status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_stat_q;

endmodule

// ----- rtl/frde_div.sv -----
`timescale 1ns / 1ps

module frde_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [frde_pkg::DIVD_W-1:0]  dividend,
	input  logic [frde_pkg::C_W-1:0]     divisor,
	output frde_pkg::frde_div_stat_t     stat,
	output logic [frde_pkg::DIVD_W-1:0]  quotient,
	output logic [frde_pkg::C_W-1:0]     remainder
);
	import frde_pkg::*;

	localparam int STEP_W = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] dq_q;
	logic [C_W-1:0]    rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [C_W:0]      shifted;
	logic [C_W:0]      diff;
	logic              fits;

	assign shifted = {rem_q, dq_q[DIVD_W-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign fits    = ~diff[C_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(DIVD_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIVD_W-2:0], fits};
			rem_q <= fits ? diff[C_W-1:0] : shifted[C_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/frde_checker.sv -----
`timescale 1ns / 1ps

module frde_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [frde_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [frde_pkg::STAT_W-1:0]     m_axis_tuser
);
	import frde_pkg::*;

	hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

	busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready held after input transfer");

	error_clears_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == '0)
		else $error("rejected request carries register data");

	ok_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STAT_OK |->
			m_axis_tdata[11:8] == DIV_BYTE_CNT || m_axis_tdata[11:8] == RDIV_BYTE_CNT)
		else $error("accepted request with bad byte count");

endmodule

bind fractional_divider_register_encoder_core frde_checker u_frde_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import frde_pkg::*;

	localparam int NUM_OUTPUTS = 3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_PER_PHASE = 320;
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [TGT_W-1:0] tgt;
		logic             src;
		logic [A_W-1:0]   a;
		logic [B_W-1:0]   b;
		logic [C_W-1:0]   c;
		logic [RC_W-1:0]  rc;
	} request_t;

	typedef struct {
		frde_status_t       status;
		logic [ADDR_W-1:0]  start_address;
		logic [CNT_W-1:0]   byte_count;
		logic [BYTES_W-1:0] register_bytes;
		logic [ADDR_W-1:0]  follow_address;
		logic [FBYTE_W-1:0] follow_byte;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [OP_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STAT_W-1:0] m_axis_tuser;

	bit pll_configured [0:1];
	logic [RC_W-1:0] out_rdiv [0:NUM_OUTPUTS-1];
	logic [1:0] out_p1_hi [0:NUM_OUTPUTS-1];

	reg_write_t pending_writes [$];
	int mismatches = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	fractional_divider_register_encoder_core #(
		.NUM_OUTPUTS(NUM_OUTPUTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #4 clk = ~clk;

	initial begin
		for (int i = 0; i < 2; i++)
			pll_configured[i] = 1'b0;
		for (int i = 0; i < NUM_OUTPUTS; i++) begin
			out_rdiv[i] = '0;
			out_p1_hi[i] = '0;
		end
	end

	function automatic logic [BYTES_W-1:0] divider_bytes(input logic [A_W-1:0] a,
			input logic [B_W-1:0] b, input logic [C_W-1:0] c, input logic [RC_W-1:0] rbits,
			output logic [1:0] p1_hi);
		logic [26:0] scaled;
		logic [26:0] quo;
		logic [31:0] p1_full;
		logic [17:0] p1;
		logic [19:0] p2;
		logic [BYTES_W-1:0] r;
		scaled = {b, 7'd0};
		quo = scaled / 27'(c);
		p2 = 20'(scaled % 27'(c));
		p1_full = 32'({a, 7'd0}) + 32'(quo) - 32'd512;
		p1 = p1_full[17:0];
		r = '0;
		r[63:48] = c[15:0];
		r[47:40] = {1'b0, rbits, 2'b00, p1[17:16]};
		r[39:24] = p1[15:0];
		r[23:20] = c[19:16];
		r[19:0] = p2;
		p1_hi = p1[17:16];
		return r;
	endfunction

	function automatic reg_write_t encode_request(input request_t r);
		reg_write_t w;
		logic [1:0] p1_hi;
		w.status = STAT_INVALID;
		w.start_address = '0;
		w.byte_count = '0;
		w.register_bytes = '0;
		w.follow_address = '0;
		w.follow_byte = '0;
		case (r.op)
			OP_PLL: begin
				if (r.a >= 15 && r.a <= 90 && r.c != 0 && r.tgt <= 1) begin
					w.register_bytes = divider_bytes(r.a, r.b, r.c, 3'd0, p1_hi);
					w.start_address = (r.tgt == 0) ? PLL_A_ADDR : PLL_B_ADDR;
					w.byte_count = DIV_BYTE_CNT;
					w.follow_address = PLL_RST_ADDR;
					w.follow_byte = PLL_RST_BYTE;
					pll_configured[r.tgt[0]] = 1'b1;
					w.status = STAT_OK;
				end
			end
			OP_MS: begin
				if (r.a >= 4 && r.a <= 2048 && r.c != 0) begin
					if (!pll_configured[r.src]) begin
						w.status = STAT_NOT_ALLOWED;
					end else if (r.tgt < NUM_OUTPUTS) begin
						w.register_bytes = divider_bytes(r.a, r.b, r.c, out_rdiv[r.tgt], p1_hi);
						out_p1_hi[r.tgt] = p1_hi;
						w.start_address = MS_BASE_ADDR + {3'd0, r.tgt, 3'd0};
						w.byte_count = DIV_BYTE_CNT;
						w.follow_address = CLK_CTRL_BASE + {6'd0, r.tgt};
						w.follow_byte = CLK_CTRL_BYTE | (r.src ? CLK_CTRL_PLLB : 8'h00) |
							((r.b == 0) ? CLK_CTRL_INT : 8'h00);
						w.status = STAT_OK;
					end
				end
			end
			OP_RDIV: begin
				if (r.tgt < NUM_OUTPUTS) begin
					out_rdiv[r.tgt] = r.rc;
					w.start_address = RDIV_BASE_ADDR + {3'd0, r.tgt, 3'd0};
					w.byte_count = RDIV_BYTE_CNT;
					w.register_bytes = {1'b0, r.rc, 2'b00, out_p1_hi[r.tgt], 56'd0};
					w.status = STAT_OK;
				end
			end
			default: begin
			end
		endcase
		return w;
	endfunction

	function automatic request_t make_req(input logic [OP_W-1:0] op, input logic [TGT_W-1:0] tgt,
			input logic src, input logic [A_W-1:0] a, input logic [B_W-1:0] b,
			input logic [C_W-1:0] c, input logic [RC_W-1:0] rc);
		request_t r;
		r.op = op;
		r.tgt = tgt;
		r.src = src;
		r.a = a;
		r.b = b;
		r.c = c;
		r.rc = rc;
		return r;
	endfunction

	task automatic send_request(input request_t r);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, r.rc, r.c, r.b, r.a, r.src, r.tgt};
		s_axis_tuser <= r.op;
		do @(posedge clk); while (!s_axis_tready);
		pending_writes.push_back(encode_request(r));
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		reg_write_t got;
		reg_write_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = frde_status_t'(m_axis_tuser);
			got.start_address = m_axis_tdata[7:0];
			got.byte_count = m_axis_tdata[11:8];
			got.register_bytes = m_axis_tdata[75:12];
			got.follow_address = m_axis_tdata[83:76];
			got.follow_byte = m_axis_tdata[91:84];
			if (pending_writes.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: status %0d addr %0d count %0d bytes %h follow %0d/%h",
						got.status, got.start_address, got.byte_count, got.register_bytes,
						got.follow_address, got.follow_byte);
				mismatches++;
			end else begin
				want = pending_writes.pop_front();
				if (got.status !== want.status || got.start_address !== want.start_address ||
						got.byte_count !== want.byte_count ||
						got.register_bytes !== want.register_bytes ||
						got.follow_address !== want.follow_address ||
						got.follow_byte !== want.follow_byte) begin
					if (mismatches < 10) begin
						$display("mismatch: expected status %0d addr %0d count %0d bytes %h follow %0d/%h",
							want.status, want.start_address, want.byte_count, want.register_bytes,
							want.follow_address, want.follow_byte);
						$display("          actual   status %0d addr %0d count %0d bytes %h follow %0d/%h",
							got.status, got.start_address, got.byte_count, got.register_bytes,
							got.follow_address, got.follow_byte);
					end
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [C_W-1:0] random_denominator();
		case ($urandom_range(0, 3))
			0: return C_W'($urandom_range(1, 16));
			1: return C_W'($urandom_range(1, 1000));
			2: return C_W'($urandom_range(1, 20'hFFFFF));
			default: return ($urandom_range(0, 1) != 0) ? 20'hFFFFF : 20'd1;
		endcase
	endfunction

	function automatic logic [B_W-1:0] random_numerator(input logic [C_W-1:0] c);
		int k;
		k = $urandom_range(0, 99);
		if (k < 15)
			return '0;
		else if (k < 30)
			return B_W'($urandom);
		else
			return B_W'($urandom_range(0, c - 1));
	endfunction

	function automatic request_t random_request();
		request_t r;
		int k;
		k = $urandom_range(0, 99);
		r.tgt = TGT_W'($urandom);
		r.src = 1'($urandom);
		r.a = A_W'($urandom);
		r.c = random_denominator();
		r.b = random_numerator(r.c);
		r.rc = RC_W'($urandom);
		if (k < 20) begin
			r.op = OP_PLL;
			if ($urandom_range(0, 9) != 0) begin
				r.tgt = TGT_W'($urandom_range(0, 1));
				r.a = A_W'($urandom_range(15, 90));
			end
		end else if (k < 60) begin
			r.op = OP_MS;
			if ($urandom_range(0, 19) != 0) begin
				r.tgt = TGT_W'($urandom_range(0, NUM_OUTPUTS - 1));
				r.a = ($urandom_range(0, 9) == 0) ? 12'd2048 : A_W'($urandom_range(4, 2048));
			end
		end else if (k < 80) begin
			r.op = OP_RDIV;
			if ($urandom_range(0, 9) != 0)
				r.tgt = TGT_W'($urandom_range(0, NUM_OUTPUTS - 1));
		end else begin
			r.op = OP_W'($urandom);
			r.b = B_W'($urandom);
			r.c = C_W'($urandom);
		end
		return r;
	endfunction

	task automatic test_unconfigured_pll();
		send_request(make_req(OP_MS, 2'd0, 1'b0, 12'd100, 20'd0, 20'd1, 3'd0));
		send_request(make_req(OP_RDIV, 2'd0, 1'b0, 12'd0, 20'd0, 20'd0, 3'd0));
		send_request(make_req(OP_MS, 2'd3, 1'b1, 12'd2048, 20'd3, 20'd5, 3'd0));
	endtask

	task automatic test_invalid_requests();
		send_request(make_req(OP_RESERVED, 2'd3, 1'b1, 12'hFFF, 20'hFFFFF, 20'hFFFFF, 3'd7));
		send_request(make_req(OP_PLL, 2'd2, 1'b0, 12'd50, 20'd0, 20'd1, 3'd0));
		send_request(make_req(OP_PLL, 2'd0, 1'b0, 12'd14, 20'd5, 20'd9, 3'd0));
		send_request(make_req(OP_PLL, 2'd1, 1'b0, 12'd91, 20'd5, 20'd9, 3'd0));
		send_request(make_req(OP_PLL, 2'd0, 1'b0, 12'd40, 20'd5, 20'd0, 3'd0));
		send_request(make_req(OP_RDIV, 2'd3, 1'b1, 12'd0, 20'd0, 20'd0, 3'd7));
	endtask

	task automatic test_pll_programming();
		send_request(make_req(OP_PLL, 2'd0, 1'b0, 12'd15, 20'd0, 20'd1, 3'd0));
		send_request(make_req(OP_MS, 2'd0, 1'b1, 12'd100, 20'd1, 20'd3, 3'd0));
		send_request(make_req(OP_PLL, 2'd1, 1'b1, 12'd90, 20'hFFFFF, 20'hFFFFF, 3'd7));
		send_request(make_req(OP_PLL, 2'd3, 1'b0, 12'd36, 20'd1, 20'd2, 3'd0));
	endtask

	task automatic test_output_dividers();
		send_request(make_req(OP_MS, 2'd0, 1'b0, 12'd4, 20'd0, 20'd1, 3'd0));
		send_request(make_req(OP_MS, 2'd1, 1'b1, 12'd2048, 20'd1, 20'hFFFFF, 3'd0));
		send_request(make_req(OP_MS, 2'd2, 1'b0, 12'd2048, 20'hFFFFF, 20'd1, 3'd0));
		send_request(make_req(OP_MS, 2'd0, 1'b0, 12'd3, 20'd1, 20'd2, 3'd0));
		send_request(make_req(OP_MS, 2'd0, 1'b1, 12'd2049, 20'd1, 20'd2, 3'd0));
		send_request(make_req(OP_MS, 2'd1, 1'b1, 12'hFFF, 20'hFFFFF, 20'd0, 3'd7));
		send_request(make_req(OP_MS, 2'd3, 1'b0, 12'd500, 20'd7, 20'd11, 3'd0));
	endtask

	task automatic test_rdiv_codes();
		send_request(make_req(OP_RDIV, 2'd2, 1'b0, 12'd0, 20'd0, 20'd0, 3'd7));
		send_request(make_req(OP_MS, 2'd2, 1'b1, 12'd37, 20'd3, 20'd7, 3'd0));
		send_request(make_req(OP_RDIV, 2'd1, 1'b0, 12'd0, 20'd0, 20'd0, 3'd5));
	endtask

	task automatic test_random_requests();
		int idle_pct [0:3];
		int stall_pct [0:3];
		idle_pct = '{0, 84, 0, 24};
		stall_pct = '{0, 0, 84, 24};
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = idle_pct[ph];
			receiver_stall_pct = stall_pct[ph];
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				send_request(random_request());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unconfigured_pll();
		test_invalid_requests();
		test_pll_programming();
		test_output_dividers();
		test_rdiv_codes();
		test_random_requests();
		s_axis_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_writes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- fractional_divider_register_encoder_core.f -----
rtl/frde_pkg.sv
rtl/frde_div.sv
rtl/fractional_divider_register_encoder_core.sv
rtl/frde_checker.sv
tb/tb.sv
